// ===== src/sliding_window_max_top_macros.svh =====
// assertion macros shared by the sliding window maximum block
`ifndef SLIDING_WINDOW_MAX_TOP_MACROS_SVH
`define SLIDING_WINDOW_MAX_TOP_MACROS_SVH

// same-cycle implication
`define SWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swm assertion failed");

// next-cycle implication
`define SWM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swm assertion failed");

`endif

// ===== src/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// shared widths, controller states and control/status bundles of the
// sliding window maximum block
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int DATA_W         = 32;
    localparam int POS_W          = 16;
    localparam int WS_W           = 7;
    localparam int WINDOW_MAX_DEF = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRONT,
        ST_BACK,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic rd_front;
        logic drop_front;
        logic drop_back;
        logic keep_front;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_one;
        logic front_expired;
        logic back_not_greater;
        logic out_free;
    } status_t;

endpackage

// ===== src/sliding_window_max_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_max_top
// running maximum over the most recent window_size signed samples
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with sample_value and last_sample; one
//   transfer per sample. last_sample ends the sequence and clears the deque,
//   position and fill count after that sample is processed.
// output channel: out_valid / out_stall with window_max; one transfer per
//   sample once window_size samples of the sequence have arrived, none before.
// config: cfg_wr_en / cfg_wr_data write window_size (0 acts as 1, values above
//   WINDOW_MAX act as WINDOW_MAX); write only while the block is idle.
// sequence: an input transfer on an empty deque goes straight to the push;
//   else the front scan reads each expired candidate and the first live one,
//   the back scan each dropped candidate and the first greater one, and then
//   the sample is pushed and its result registered.
// throughput: a new sample is accepted only once the block is idle after the
//   push; each candidate is dropped once; the single read port of the
//   candidate ram serializes the front and back checks.
// stall: the finished result sits in an output register; the next sample is
//   accepted and scanned meanwhile, and the block holds before its push until
//   the result register is free.
// reset: window_size returns to 1, the deque and counters empty, no result.
// ----------------------------------------------------------------------------
module sliding_window_max_top #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [swm_pkg::WS_W-1:0]          cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [swm_pkg::DATA_W-1:0] sample_value,
    input  logic                              last_sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [swm_pkg::DATA_W-1:0] window_max
);

    swm_pkg::cmd_t    cmd;
    swm_pkg::status_t status;

    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    swm_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .sample_value (sample_value),
        .last_sample  (last_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .window_max   (window_max),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// ===== src/swm_ram.sv =====
// ----------------------------------------------------------------------------
// swm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/swm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swm_ctrl
// sequencer: front expiry scan, back pruning scan, then push and result
// ----------------------------------------------------------------------------
module swm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  swm_pkg::status_t status,
    output swm_pkg::cmd_t    cmd
);

    swm_pkg::state_t state_reg;
    swm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            swm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.cnt_zero)
                    begin
                        state_next = swm_pkg::ST_PUSH;
                    end
                    else
                    begin
                        cmd.rd_en    = 1'b1;
                        cmd.rd_front = 1'b1;
                        state_next   = swm_pkg::ST_FRONT;
                    end
                end
            end
            swm_pkg::ST_FRONT:
            begin
                if (status.front_expired)
                begin
                    cmd.drop_front = 1'b1;
                    if (status.cnt_one)
                    begin
                        state_next = swm_pkg::ST_PUSH;
                    end
                    else
                    begin
                        cmd.rd_en    = 1'b1;
                        cmd.rd_front = 1'b1;
                    end
                end
                else
                begin
                    cmd.keep_front = 1'b1;
                    cmd.rd_en      = 1'b1;
                    state_next     = swm_pkg::ST_BACK;
                end
            end
            swm_pkg::ST_BACK:
            begin
                if (status.back_not_greater)
                begin
                    cmd.drop_back = 1'b1;
                    if (status.cnt_one)
                    begin
                        state_next = swm_pkg::ST_PUSH;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                    end
                end
                else
                begin
                    state_next = swm_pkg::ST_PUSH;
                end
            end
            swm_pkg::ST_PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = swm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swm_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != swm_pkg::ST_IDLE);

endmodule

// ===== src/swm_datapath.sv =====
// ----------------------------------------------------------------------------
// swm_datapath
// candidate deque (ram plus pointers), sequence counters, window size
// register and output register
// ----------------------------------------------------------------------------
`include "sliding_window_max_top_macros.svh"

module swm_datapath #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [swm_pkg::WS_W-1:0]         cfg_wr_data,
    input  logic signed [swm_pkg::DATA_W-1:0] sample_value,
    input  logic                             last_sample,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [swm_pkg::DATA_W-1:0] window_max,
    input  swm_pkg::cmd_t                    cmd,
    output swm_pkg::status_t                 status
);

    localparam int PTR_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int ENT_W = swm_pkg::POS_W + swm_pkg::DATA_W;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW_MAX - 1);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_SLOT : p - 1'b1;
    endfunction

    logic [swm_pkg::WS_W-1:0]          ws_reg, ws_next;
    logic [PTR_W-1:0]                  front_reg, front_next;
    logic [PTR_W-1:0]                  back_reg, back_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [swm_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [swm_pkg::WS_W-1:0]          filled_reg, filled_next;
    logic                              out_valid_reg, out_valid_next;
    logic signed [swm_pkg::DATA_W-1:0] val_reg, val_next;
    logic                              last_reg, last_next;
    logic signed [swm_pkg::DATA_W-1:0] front_val_reg, front_val_next;
    logic signed [swm_pkg::DATA_W-1:0] out_data_reg, out_data_next;

    logic [swm_pkg::WS_W-1:0]          k;
    logic [swm_pkg::WS_W-1:0]          filled_inc;
    logic                              emit;
    logic [ENT_W-1:0]                  rd_data;
    logic [ENT_W-1:0]                  wr_data;
    logic [PTR_W-1:0]                  rd_addr;
    logic signed [swm_pkg::DATA_W-1:0] rd_val;
    logic [swm_pkg::POS_W-1:0]         rd_pos;
    logic [swm_pkg::POS_W-1:0]         age;
    logic [PTR_W-1:0]                  front_step;
    logic [PTR_W-1:0]                  back_step;

    // effective window size
    always_comb
    begin
        if (ws_reg == '0)
        begin
            k = swm_pkg::WS_W'(1);
        end
        else if (int'(ws_reg) > WINDOW_MAX)
        begin
            k = swm_pkg::WS_W'(WINDOW_MAX);
        end
        else
        begin
            k = ws_reg;
        end
    end

    assign rd_val  = rd_data[swm_pkg::DATA_W-1:0];
    assign rd_pos  = rd_data[ENT_W-1:swm_pkg::DATA_W];
    assign age     = pos_reg - rd_pos;
    assign wr_data = {pos_reg, val_reg};

    assign status.cnt_zero         = (count_reg == '0);
    assign status.cnt_one          = (count_reg == CNT_W'(1));
    assign status.front_expired    = (age >= swm_pkg::POS_W'(k));
    assign status.back_not_greater = !(rd_val > val_reg);
    assign status.out_free         = !out_valid_reg || !out_stall;

    assign front_step = cmd.drop_front ? next_slot(front_reg) : front_reg;
    assign back_step  = cmd.drop_back  ? prev_slot(back_reg)  : back_reg;
    assign rd_addr    = cmd.rd_front   ? front_step : prev_slot(back_step);

    assign filled_inc = (filled_reg < k) ? filled_reg + 1'b1 : k;
    assign emit       = (filled_inc >= k);

    always_comb
    begin
        ws_next        = cfg_wr_en ? cfg_wr_data : ws_reg;
        front_next     = front_step;
        back_next      = back_step;
        count_next     = count_reg;
        pos_next       = pos_reg;
        filled_next    = filled_reg;
        out_valid_next = out_valid_reg && out_stall;
        val_next       = cmd.accept ? sample_value : val_reg;
        last_next      = cmd.accept ? last_sample : last_reg;
        front_val_next = cmd.keep_front ? rd_val : front_val_reg;
        out_data_next  = out_data_reg;
        if (cmd.drop_front || cmd.drop_back)
        begin
            count_next = count_reg - 1'b1;
        end
        if (cmd.push)
        begin
            out_valid_next = emit;
            out_data_next  = status.cnt_zero ? val_reg : front_val_reg;
            if (last_reg)
            begin
                front_next  = '0;
                back_next   = '0;
                count_next  = '0;
                pos_next    = '0;
                filled_next = '0;
            end
            else
            begin
                back_next   = next_slot(back_reg);
                count_next  = count_reg + 1'b1;
                pos_next    = pos_reg + 1'b1;
                filled_next = filled_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= swm_pkg::WS_W'(1);
            front_reg     <= '0;
            back_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            filled_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ws_reg        <= ws_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        last_reg      <= last_next;
        front_val_reg <= front_val_next;
        out_data_reg  <= out_data_next;
    end

    swm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (WINDOW_MAX)
    ) u_cand_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (back_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid  = out_valid_reg;
    assign window_max = out_data_reg;

    `SWM_ASSERT_IMP(a_no_pop_empty, clk, rst_n, cmd.drop_front || cmd.drop_back, count_reg != '0)
    `SWM_ASSERT_IMP(a_no_overflow, clk, rst_n, cmd.push, int'(count_reg) < WINDOW_MAX)
    `SWM_ASSERT_IMP(a_push_out_free, clk, rst_n, cmd.push, status.out_free)
    `SWM_ASSERT_NXT(a_last_clears, clk, rst_n, cmd.push && last_reg,
        count_reg == '0 && pos_reg == '0 && filled_reg == '0)

endmodule
